[hw/rtl/germ_pkg.sv]
package germ_pkg;

  localparam int ANGLE_WIDTH  = 16;
  localparam int FRAC_WIDTH   = 14;
  localparam int CORDIC_STEPS = 30;
  localparam int LAT          = CORDIC_STEPS + 9;
  localparam int CW           = 34;
  localparam int OUT_WIDTH    = FRAC_WIDTH + 2;
  localparam int IN_DATA_W    = ((4 * ANGLE_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_W   = ((9 * OUT_WIDTH + 7) / 8) * 8;
  localparam int OUT_SHIFT    = 30 - FRAC_WIDTH;

  localparam logic signed [31:0] CORDIC_START = 32'sh26DD3B6A;
  localparam logic signed [32:0] OUT_HALF     = 33'((2 ** OUT_SHIFT) / 2);
  localparam logic signed [32:0] OUT_LIM      = 33'(2 ** FRAC_WIDTH);

  typedef logic [ANGLE_WIDTH-1:0] angle_t;
  typedef logic signed [31:0]     trig_t;
  typedef logic signed [63:0]     prod_t;
  typedef logic signed [CW-1:0]   cw_t;
  typedef logic signed [OUT_WIDTH-1:0] out_t;

  function automatic cw_t atan_val(input int i);
    cw_t r;
    case (i)
      0:       r = 34'sd536870912;
      1:       r = 34'sd316933406;
      2:       r = 34'sd167458907;
      3:       r = 34'sd85004756;
      4:       r = 34'sd42667331;
      5:       r = 34'sd21354465;
      6:       r = 34'sd10679838;
      7:       r = 34'sd5340245;
      8:       r = 34'sd2670163;
      9:       r = 34'sd1335087;
      10:      r = 34'sd667544;
      11:      r = 34'sd333772;
      12:      r = 34'sd166886;
      13:      r = 34'sd83443;
      14:      r = 34'sd41722;
      15:      r = 34'sd20861;
      16:      r = 34'sd10430;
      17:      r = 34'sd5215;
      18:      r = 34'sd2608;
      19:      r = 34'sd1304;
      20:      r = 34'sd652;
      21:      r = 34'sd326;
      22:      r = 34'sd163;
      23:      r = 34'sd81;
      24:      r = 34'sd41;
      25:      r = 34'sd20;
      26:      r = 34'sd10;
      27:      r = 34'sd5;
      28:      r = 34'sd3;
      29:      r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic trig_t rnd30(input prod_t p);
    prod_t s;
    prod_t t;
    s = p + 64'sh20000000;
    t = s >>> 30;
    return t[31:0];
  endfunction

  function automatic out_t to_out(input trig_t q);
    logic signed [32:0] v;
    logic signed [32:0] r;
    v = 33'(q) + OUT_HALF;
    r = v >>> OUT_SHIFT;
    if (r > OUT_LIM) begin
      r = OUT_LIM;
    end else if (r < -OUT_LIM) begin
      r = -OUT_LIM;
    end
    return r[OUT_WIDTH-1:0];
  endfunction

endpackage

[hw/rtl/germ_cordic.sv]
module germ_cordic (
  input  logic            clk_i,
  input  logic            en_i,
  input  germ_pkg::angle_t angle_i,
  output germ_pkg::trig_t sin_o,
  output germ_pkg::trig_t cos_o
);
  import germ_pkg::*;

  cw_t   x_q [0:CORDIC_STEPS];
  cw_t   y_q [0:CORDIC_STEPS];
  cw_t   z_q [0:CORDIC_STEPS];
  logic  flip_q [0:CORDIC_STEPS];
  trig_t sin_q;
  trig_t cos_q;

  logic [31:0] wide_a;
  logic        flip_d;
  logic [31:0] turned_a;

  assign wide_a   = {angle_i, {(32 - ANGLE_WIDTH){1'b0}}};
  assign flip_d   = wide_a[31] ^ wide_a[30];
  assign turned_a = {wide_a[31] ^ flip_d, wide_a[30:0]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= CW'(CORDIC_START);
      y_q[0]    <= '0;
      z_q[0]    <= CW'($signed(turned_a));
      flip_q[0] <= flip_d;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    cw_t dx;
    cw_t dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][CW-1]) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - atan_val(i);
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + atan_val(i);
        end
        flip_q[i+1] <= flip_q[i];
      end
    end
  end

  cw_t neg_x;
  cw_t neg_y;
  assign neg_x = -x_q[CORDIC_STEPS];
  assign neg_y = -y_q[CORDIC_STEPS];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= flip_q[CORDIC_STEPS] ? neg_y[31:0] : y_q[CORDIC_STEPS][31:0];
      cos_q <= flip_q[CORDIC_STEPS] ? neg_x[31:0] : x_q[CORDIC_STEPS][31:0];
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

[hw/rtl/gimbal_euler_to_rotation_matrix.sv]
// Throughput: one item per cycle while the output is not stalled; a 30-stage
// CORDIC per angle and six multiply/round stages for the three matrix products
// set the depth.
// A stall on the output holds every stage at once.
// Reset: asynchronous, active low; clears the stage valid bits only.
module gimbal_euler_to_rotation_matrix (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // gimbal_pitch_angle, yaw_angle, pitch_angle, roll_angle
  input  logic [germ_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22
  output logic [germ_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);
  import germ_pkg::*;

  logic en;
  logic vld_q [0:LAT-1];

  assign en = !vld_q[LAT-1] || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LAT; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= s_axis_tvalid_i;
      for (int k = 1; k < LAT; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  trig_t sn [4];
  trig_t cs [4];

  for (genvar a = 0; a < 4; a++) begin : g_trig
    germ_cordic u_cordic (
      .clk_i   (clk_i),
      .en_i    (en),
      .angle_i (s_axis_tdata_i[a*ANGLE_WIDTH +: ANGLE_WIDTH]),
      .sin_o   (sn[a]),
      .cos_o   (cs[a])
    );
  end

  // stage A: Rgp * Rz
  prod_t pa_q [4];
  trig_t sg_a_q, cg_a_q, sy_a_q, cy_a_q, sp_a_q, cp_a_q, sr_a_q, cr_a_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pa_q[0] <= cs[0] * cs[1];
      pa_q[1] <= cs[0] * sn[1];
      pa_q[2] <= sn[0] * cs[1];
      pa_q[3] <= sn[0] * sn[1];
      sg_a_q <= sn[0]; cg_a_q <= cs[0];
      sy_a_q <= sn[1]; cy_a_q <= cs[1];
      sp_a_q <= sn[2]; cp_a_q <= cs[2];
      sr_a_q <= sn[3]; cr_a_q <= cs[3];
    end
  end

  trig_t t_q [3][3];
  trig_t sp_t_q, cp_t_q, sr_t_q, cr_t_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_q[0][0] <= rnd30(pa_q[0]);
      t_q[0][1] <= rnd30(-pa_q[1]);
      t_q[0][2] <= -sg_a_q;
      t_q[1][0] <= sy_a_q;
      t_q[1][1] <= cy_a_q;
      t_q[1][2] <= '0;
      t_q[2][0] <= rnd30(pa_q[2]);
      t_q[2][1] <= rnd30(-pa_q[3]);
      t_q[2][2] <= cg_a_q;
      sp_t_q <= sp_a_q; cp_t_q <= cp_a_q;
      sr_t_q <= sr_a_q; cr_t_q <= cr_a_q;
    end
  end

  // stage B: times Ry
  prod_t pb_q [3][4];
  trig_t mid_b_q [3];
  trig_t sr_b_q, cr_b_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        pb_q[r][0] <= t_q[r][0] * cp_t_q;
        pb_q[r][1] <= t_q[r][2] * sp_t_q;
        pb_q[r][2] <= t_q[r][0] * sp_t_q;
        pb_q[r][3] <= t_q[r][2] * cp_t_q;
        mid_b_q[r] <= t_q[r][1];
      end
      sr_b_q <= sr_t_q; cr_b_q <= cr_t_q;
    end
  end

  trig_t m_q [3][3];
  trig_t sr_m_q, cr_m_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        m_q[r][0] <= rnd30(pb_q[r][0] - pb_q[r][1]);
        m_q[r][1] <= mid_b_q[r];
        m_q[r][2] <= rnd30(pb_q[r][2] + pb_q[r][3]);
      end
      sr_m_q <= sr_b_q; cr_m_q <= cr_b_q;
    end
  end

  // stage C: times Rx
  prod_t pc_q [3][4];
  trig_t left_c_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        pc_q[r][0] <= m_q[r][1] * cr_m_q;
        pc_q[r][1] <= m_q[r][2] * sr_m_q;
        pc_q[r][2] <= m_q[r][1] * sr_m_q;
        pc_q[r][3] <= m_q[r][2] * cr_m_q;
        left_c_q[r] <= m_q[r][0];
      end
    end
  end

  trig_t f_q [3][3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        f_q[r][0] <= left_c_q[r];
        f_q[r][1] <= rnd30(pc_q[r][0] + pc_q[r][1]);
        f_q[r][2] <= rnd30(pc_q[r][3] - pc_q[r][2]);
      end
    end
  end

  // mount rotations: rows become -F1, -F2, F0
  out_t out_q [9];
  out_t o1 [3];
  out_t o2 [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      o1[j] = to_out(f_q[1][j]);
      o2[j] = to_out(f_q[2][j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        out_q[j]     <= -o1[j];
        out_q[3 + j] <= -o2[j];
        out_q[6 + j] <= to_out(f_q[0][j]);
      end
    end
  end

  always_comb begin
    m_axis_tdata_o = '0;
    for (int k = 0; k < 9; k++) begin
      m_axis_tdata_o[k*OUT_WIDTH +: OUT_WIDTH] = out_q[k];
    end
  end

endmodule
